### hdl/phg_pkg.sv
// ----------------------------------------------------------------------------
// PES header generator package
// Shared types, constants and the header byte function.
// ----------------------------------------------------------------------------
package phg_pkg;

    localparam int unsigned MAX_PAYLOAD = 65500;
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [1:0] REG_MPEG2 = 2'd0;
    localparam logic [1:0] REG_ALIGN = 2'd1;
    localparam logic [1:0] REG_STUFF = 2'd2;

    localparam logic [1:0] FLAGS_NONE    = 2'd0;
    localparam logic [1:0] FLAGS_PTS     = 2'd2;
    localparam logic [1:0] FLAGS_PTS_DTS = 2'd3;

    localparam logic [7:0] ID_PRIVATE_1 = 8'hBD;
    localparam logic [7:0] ID_EXTENDED  = 8'hFD;
    localparam logic [7:0] BYTE_MARKER  = 8'h0F;
    localparam logic [7:0] BYTE_EXT_FLG = 8'h81;
    localparam logic [7:0] BYTE_HIGH    = 8'h80;
    localparam logic [7:0] BYTE_STUFF   = 8'hFF;
    localparam logic [3:0] AC3_NIBBLE   = 4'h8;

    localparam logic [3:0] BASE_SHORT = 4'd6;
    localparam logic [3:0] BASE_MPEG1 = 4'd6;
    localparam logic [3:0] BASE_MPEG2 = 4'd9;

    typedef struct packed {
        logic        align;
        logic [7:0]  sid;
        logic [15:0] len;
        logic [1:0]  flags;
        logic        ext;
        logic [6:0]  extid;
        logic [7:0]  hs_byte;
        logic [32:0] pts;
        logic [32:0] dts;
        logic [3:0]  opt_base;
        logic [3:0]  ts_len;
        logic [1:0]  mark_len;
        logic [8:0]  body_len;
        logic [7:0]  pid;
        logic [8:0]  total;
        logic [5:0]  words;
    } t_desc;

    function automatic logic [7:0] ts_byte(logic [1:0] pre, logic [32:0] ts, logic [2:0] k);
        logic [7:0] b;
        unique case (k)
            3'd0:    b = {2'b00, pre, ts[32:30], 1'b1};
            3'd1:    b = ts[29:22];
            3'd2:    b = {ts[21:15], 1'b1};
            3'd3:    b = ts[14:7];
            default: b = {ts[6:0], 1'b1};
        endcase
        return b;
    endfunction

    function automatic logic [7:0] hdr_byte(t_desc d, logic [8:0] p);
        logic [8:0] q;
        logic [8:0] r;
        logic [8:0] s;
        logic       second;
        logic [2:0] k;
        logic [7:0] b;
        q      = p - 9'(d.opt_base);
        r      = q - 9'(d.ts_len);
        s      = q - d.body_len;
        second = (q >= 9'd5);
        k      = second ? 3'(q - 9'd5) : 3'(q);
        if (p < 9'(d.opt_base)) begin
            unique case (p[3:0])
                4'd2:    b = 8'h01;
                4'd3:    b = d.sid;
                4'd4:    b = d.len[15:8];
                4'd5:    b = d.len[7:0];
                4'd6:    b = BYTE_HIGH | {5'd0, d.align, 2'b00};
                4'd7:    b = {d.flags, 5'd0, d.ext};
                4'd8:    b = d.hs_byte;
                default: b = 8'h00;
            endcase
        end else if (q < d.body_len) begin
            if (q < 9'(d.ts_len)) begin
                b = second ? ts_byte(2'd1, d.dts, k) : ts_byte(d.flags, d.pts, k);
            end else if (r < 9'(d.mark_len)) begin
                unique case (r[1:0])
                    2'd0:    b = BYTE_MARKER;
                    2'd1:    b = BYTE_EXT_FLG;
                    default: b = BYTE_HIGH | {1'b0, d.extid};
                endcase
            end else begin
                b = BYTE_STUFF;
            end
        end else if (s == 9'd0) begin
            b = d.pid;
        end else begin
            b = 8'h00;
        end
        return b;
    endfunction

endpackage

### hdl/pes_header_generator.sv
// ----------------------------------------------------------------------------
// PES header generator
// Builds MPEG-1 or MPEG-2 PES headers and emits them as 64-bit words.
// The first word of a request passes the queue and then the output register.
// Throughput: one word per cycle while pop is held, so a request of N header
// bytes gives ceil(N/8) words (1 to 34), one 64-bit word built per cycle.
// Reset is synchronous: queues empty, mpeg2_mode 1, align_flag 0, stuffing 0.
// ----------------------------------------------------------------------------
module pes_header_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic [32:0] i_pts,
    input  logic [32:0] i_dts,
    input  logic [23:0] i_payload_size,
    input  logic [15:0] i_stream_code,
    input  logic        i_is_video,
    input  logic        i_is_mpeg_video,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] o_header_word,
    output logic [3:0]  o_byte_count,
    output logic [8:0]  o_header_length,
    output logic        o_last_word
);

    logic           r_mpeg2;
    logic           r_align;
    logic [7:0]     r_stuff;
    logic           n_mpeg2;
    logic           n_align;
    logic [7:0]     n_stuff;
    logic           wr_en;
    phg_pkg::t_desc cls_desc;
    phg_pkg::t_desc head_desc;
    logic           head_valid;
    logic           head_pop;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        n_mpeg2 = r_mpeg2;
        n_align = r_align;
        n_stuff = r_stuff;
        prdata  = '0;
        unique case (paddr[3:2])
            phg_pkg::REG_MPEG2: begin
                prdata = {31'd0, r_mpeg2};
                if (wr_en) n_mpeg2 = pwdata[0];
            end
            phg_pkg::REG_ALIGN: begin
                prdata = {31'd0, r_align};
                if (wr_en) n_align = pwdata[0];
            end
            phg_pkg::REG_STUFF: begin
                prdata = {24'd0, r_stuff};
                if (wr_en) n_stuff = pwdata[7:0];
            end
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mpeg2 <= 1'b1;
            r_align <= 1'b0;
            r_stuff <= 8'd0;
        end else begin
            r_mpeg2 <= n_mpeg2;
            r_align <= n_align;
            r_stuff <= n_stuff;
        end
    end

    phg_classify u_classify (
        .i_mpeg2         (r_mpeg2),
        .i_align         (r_align),
        .i_stuff         (r_stuff),
        .i_pts           (i_pts),
        .i_dts           (i_dts),
        .i_payload_size  (i_payload_size),
        .i_stream_code   (i_stream_code),
        .i_is_video      (i_is_video),
        .i_is_mpeg_video (i_is_mpeg_video),
        .o_desc          (cls_desc)
    );

    phg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (cls_desc),
        .o_full  (full),
        .i_pop   (head_pop),
        .o_valid (head_valid),
        .o_head  (head_desc)
    );

    phg_emit u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (head_valid),
        .i_desc          (head_desc),
        .o_pop           (head_pop),
        .o_empty         (empty),
        .i_take          (pop),
        .o_header_word   (o_header_word),
        .o_byte_count    (o_byte_count),
        .o_header_length (o_header_length),
        .o_last_word     (o_last_word)
    );

endmodule

### hdl/phg_classify.sv
// ----------------------------------------------------------------------------
// PES header classifier
// Sorts a request into its header syntax and lays out its header regions.
// ----------------------------------------------------------------------------
module phg_classify (
    input  logic                i_mpeg2,
    input  logic                i_align,
    input  logic [7:0]          i_stuff,
    input  logic [32:0]         i_pts,
    input  logic [32:0]         i_dts,
    input  logic [23:0]         i_payload_size,
    input  logic [15:0]         i_stream_code,
    input  logic                i_is_video,
    input  logic                i_is_mpeg_video,
    output phg_pkg::t_desc      o_desc
);

    logic [7:0]  hi;
    logic [7:0]  lo;
    logic        priv;
    logic        ext;
    logic        short_hdr;
    logic        unb;
    logic [2:0]  extra;
    logic        both;
    logic [1:0]  flags2;
    logic [1:0]  flags1;
    logic [1:0]  flags;
    logic [1:0]  nts;
    logic [3:0]  ts_len;
    logic [7:0]  hs_base;
    logic [8:0]  hs;
    logic [3:0]  used;
    logic [8:0]  body_len;
    logic [15:0] len;
    logic [3:0]  add1;
    logic [8:0]  total;
    logic [8:0]  rounded;

    always_comb begin
        hi    = i_stream_code[15:8];
        lo    = i_stream_code[7:0];
        priv  = (hi == phg_pkg::ID_PRIVATE_1);
        ext   = (hi == phg_pkg::ID_EXTENDED);
        unb   = (i_payload_size > 24'(phg_pkg::MAX_PAYLOAD));
        extra = priv ? ((lo[7:4] == phg_pkg::AC3_NIBBLE) ? 3'd4 : 3'd1) : 3'd0;
        short_hdr = 1'b0;
        if (hi == 8'h00) begin
            unique case (lo)
                8'hBC, 8'hBE, 8'hBF, 8'hF0, 8'hF1, 8'hF2, 8'hF8, 8'hFF: short_hdr = 1'b1;
                default: short_hdr = 1'b0;
            endcase
        end

        both   = (i_pts != 33'd0) && (i_dts != 33'd0);
        flags2 = (both && ((i_pts != i_dts) || (i_is_video && !i_is_mpeg_video))) ?
                 phg_pkg::FLAGS_PTS_DTS :
                 ((i_pts != 33'd0) ? phg_pkg::FLAGS_PTS : phg_pkg::FLAGS_NONE);
        flags1 = (both && ((i_pts != i_dts) || i_is_video)) ? phg_pkg::FLAGS_PTS_DTS :
                 ((i_pts != 33'd0) ? phg_pkg::FLAGS_PTS : phg_pkg::FLAGS_NONE);
        flags  = short_hdr ? phg_pkg::FLAGS_NONE : (i_mpeg2 ? flags2 : flags1);
        unique case (flags)
            phg_pkg::FLAGS_PTS_DTS: nts = 2'd2;
            phg_pkg::FLAGS_PTS:     nts = 2'd1;
            default:                nts = 2'd0;
        endcase
        ts_len = {nts, 2'b00} + {2'b00, nts};

        unique case (flags2)
            phg_pkg::FLAGS_PTS_DTS: hs_base = 8'd10;
            phg_pkg::FLAGS_PTS:     hs_base = 8'd5;
            default:                hs_base = 8'd0;
        endcase
        if (i_stuff != 8'd0) begin
            hs_base = i_stuff;
        end
        hs   = {1'b0, hs_base} + (ext ? 9'd3 : 9'd0);
        used = ts_len + (ext ? 4'd3 : 4'd0);

        unique case (flags1)
            phg_pkg::FLAGS_PTS_DTS: add1 = 4'd10;
            phg_pkg::FLAGS_PTS:     add1 = 4'd5;
            default:                add1 = 4'd1;
        endcase

        o_desc          = '0;
        o_desc.align    = i_align;
        o_desc.sid      = priv ? phg_pkg::ID_PRIVATE_1 : (ext ? phg_pkg::ID_EXTENDED : lo);
        o_desc.flags    = flags;
        o_desc.ext      = ext;
        o_desc.extid    = lo[6:0];
        o_desc.hs_byte  = hs[7:0];
        o_desc.pts      = i_pts;
        o_desc.dts      = i_dts;
        o_desc.ts_len   = ts_len;
        o_desc.pid      = lo;

        priority if (short_hdr) begin
            len               = i_payload_size[15:0];
            body_len          = 9'd0;
            o_desc.opt_base   = phg_pkg::BASE_SHORT;
            o_desc.mark_len   = 2'd0;
        end else if (i_mpeg2) begin
            len               = i_payload_size[15:0] + 16'(extra) + 16'd3 + 16'(hs);
            body_len          = (hs >= 9'(used)) ? hs : 9'(used);
            o_desc.opt_base   = phg_pkg::BASE_MPEG2;
            o_desc.mark_len   = ext ? 2'd3 : 2'd0;
        end else begin
            len               = i_payload_size[15:0] + 16'(extra) + 16'(add1);
            body_len          = (flags == phg_pkg::FLAGS_NONE) ? 9'd1 : 9'(ts_len);
            o_desc.opt_base   = phg_pkg::BASE_MPEG1;
            o_desc.mark_len   = (flags == phg_pkg::FLAGS_NONE) ? 2'd1 : 2'd0;
        end
        o_desc.len      = unb ? 16'd0 : len;
        o_desc.body_len = body_len;
        total           = 9'(o_desc.opt_base) + body_len + 9'(short_hdr ? 3'd0 : extra);
        rounded         = total + 9'd7;
        o_desc.total    = total;
        o_desc.words    = rounded[8:3];
    end

endmodule

### hdl/phg_queue.sv
// ----------------------------------------------------------------------------
// PES header request queue
// Short queue of classified requests between the classifier and the emitter.
// ----------------------------------------------------------------------------
module phg_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  phg_pkg::t_desc i_desc,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output phg_pkg::t_desc o_head
);

    localparam int unsigned PW = $clog2(phg_pkg::QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(phg_pkg::QUEUE_DEPTH + 1);

    phg_pkg::t_desc r_mem [phg_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;
    logic [PW-1:0]  n_wr;
    logic [PW-1:0]  n_rd;
    logic [CW-1:0]  n_cnt;
    logic           do_push;
    logic           do_pop;

    always_comb begin
        o_full  = (r_cnt == CW'(phg_pkg::QUEUE_DEPTH));
        o_valid = (r_cnt != '0);
        o_head  = r_mem[r_rd];
        do_push = i_push && !o_full;
        do_pop  = i_pop && o_valid;
        n_wr    = do_push ? PW'(32'(r_wr) + 1) : r_wr;
        n_rd    = do_pop ? PW'(32'(r_rd) + 1) : r_rd;
        n_cnt   = r_cnt + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

endmodule

### hdl/phg_emit.sv
// ----------------------------------------------------------------------------
// PES header word emitter
// Builds one 64-bit header word per cycle from the queue head unless stalled.
// ----------------------------------------------------------------------------
module phg_emit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  phg_pkg::t_desc i_desc,
    output logic           o_pop,
    output logic           o_empty,
    input  logic           i_take,
    output logic [63:0]    o_header_word,
    output logic [3:0]     o_byte_count,
    output logic [8:0]     o_header_length,
    output logic           o_last_word
);

    logic [5:0]  r_word;
    logic        r_out_valid;
    logic [63:0] r_header_word;
    logic [3:0]  r_byte_count;
    logic [8:0]  r_header_length;
    logic        r_last_word;
    logic [5:0]  n_word;
    logic        n_out_valid;
    logic [63:0] n_header_word;
    logic [3:0]  n_byte_count;
    logic        last;
    logic        advance;
    logic [8:0]  base;
    logic [8:0]  pos;
    logic [8:0]  remain;

    always_comb begin
        advance = i_valid && (!r_out_valid || i_take);
        last    = (r_word == (i_desc.words - 6'd1));
        base    = {r_word, 3'b000};
        remain  = i_desc.total - base;
        n_header_word = '0;
        for (int k = 0; k < 8; k++) begin
            pos = base + 9'(k);
            if (pos < i_desc.total) begin
                n_header_word[63 - 8*k -: 8] = phg_pkg::hdr_byte(i_desc, pos);
            end
        end
        n_byte_count = last ? remain[3:0] : 4'd8;
        n_word       = advance ? (last ? 6'd0 : r_word + 6'd1) : r_word;
        n_out_valid  = advance ? 1'b1 : (i_take ? 1'b0 : r_out_valid);
        o_pop        = advance && last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_word      <= n_word;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_header_word   <= n_header_word;
            r_byte_count    <= n_byte_count;
            r_header_length <= i_desc.total;
            r_last_word     <= last;
        end
    end

    assign o_empty         = !r_out_valid;
    assign o_header_word   = r_header_word;
    assign o_byte_count    = r_byte_count;
    assign o_header_length = r_header_length;
    assign o_last_word     = r_last_word;

endmodule

### hdl/phg_checker.sv
// ----------------------------------------------------------------------------
// PES header generator checker
// Port-level assertions on the request queues and the emitted words.
// ----------------------------------------------------------------------------
module phg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [63:0] o_header_word,
    input logic [3:0]  o_byte_count,
    input logic [8:0]  o_header_length,
    input logic        o_last_word
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("Queues are not empty after reset.");

    a_full_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_last_word) |-> (o_byte_count == 4'd8))
        else $error("A word before the last one is not full.");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_byte_count != 4'd0) && (o_byte_count <= 4'd8))
        else $error("The byte count is out of range.");

    a_header_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_last_word) |=> !empty && $stable(o_header_length))
        else $error("A header was broken off before its last word.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty && $stable(o_header_word))
        else $error("A waiting word changed before it was taken.");

endmodule

bind pes_header_generator phg_checker u_phg_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .full            (full),
    .empty           (empty),
    .pop             (pop),
    .o_header_word   (o_header_word),
    .o_byte_count    (o_byte_count),
    .o_header_length (o_header_length),
    .o_last_word     (o_last_word)
);

### verif/pes_header_checker.sv
// ----------------------------------------------------------------------------
// PES header generator checker
// Watches the register port and both request queues of the header generator.
// It predicts the header words of every accepted request and compares each
// popped word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module pes_header_checker
    import phg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        push,
    input  logic        full,
    input  logic [32:0] i_pts,
    input  logic [32:0] i_dts,
    input  logic [23:0] i_payload_size,
    input  logic [15:0] i_stream_code,
    input  logic        i_is_video,
    input  logic        i_is_mpeg_video,
    input  logic        empty,
    input  logic        pop,
    input  logic [63:0] o_header_word,
    input  logic [3:0]  o_byte_count,
    input  logic [8:0]  o_header_length,
    input  logic        o_last_word,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  count;
        logic [8:0]  hlen;
        logic        last;
    } hdr_word_t;

    hdr_word_t  expected_words[$];
    logic [7:0] hdr_bytes[$];
    logic       cfg_mpeg2;
    logic       cfg_align;
    logic [7:0] cfg_stuff;
    int         err_count = 0;

    function automatic logic is_short_id(logic [15:0] code);
        case (code)
            16'h00BC, 16'h00BE, 16'h00BF, 16'h00F0,
            16'h00F1, 16'h00F2, 16'h00F8, 16'h00FF: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    task automatic append_timestamp(input logic [3:0] prefix, input logic [32:0] ts);
        hdr_bytes.push_back({prefix, ts[32:30], 1'b1});
        hdr_bytes.push_back(ts[29:22]);
        hdr_bytes.push_back({ts[21:15], 1'b1});
        hdr_bytes.push_back(ts[14:7]);
        hdr_bytes.push_back({ts[6:0], 1'b1});
    endtask

    task automatic build_header(input logic [32:0] pts, input logic [32:0] dts,
                                input logic [23:0] size, input logic [15:0] code,
                                input logic video, input logic mpgv);
        logic [7:0]  sid;
        logic [7:0]  pid;
        logic [6:0]  extid;
        logic [1:0]  flags;
        logic [15:0] len;
        logic        priv;
        logic        ext;
        logic        unbounded;
        int unsigned extra;
        int unsigned hs;
        int unsigned used;
        int unsigned add;
        int unsigned nbytes;
        int unsigned cnt;
        int unsigned i;
        int unsigned k;
        hdr_word_t   w;
        hdr_bytes.delete();
        sid       = code[7:0];
        pid       = 8'h00;
        extid     = 7'd0;
        priv      = 1'b0;
        ext       = 1'b0;
        extra     = 0;
        unbounded = (size > MAX_PAYLOAD);
        if (code[15:8] == ID_PRIVATE_1) begin
            priv  = 1'b1;
            pid   = code[7:0];
            sid   = ID_PRIVATE_1;
            extra = (pid[7:4] == AC3_NIBBLE) ? 4 : 1;
        end else if (code[15:8] == ID_EXTENDED) begin
            ext   = 1'b1;
            extid = code[6:0];
            sid   = ID_EXTENDED;
        end
        hdr_bytes.push_back(8'h00);
        hdr_bytes.push_back(8'h00);
        hdr_bytes.push_back(8'h01);
        hdr_bytes.push_back(sid);
        if (is_short_id(code)) begin
            len = unbounded ? 16'd0 : size[15:0];
            hdr_bytes.push_back(len[15:8]);
            hdr_bytes.push_back(len[7:0]);
        end else begin
            if (cfg_mpeg2) begin
                hs   = cfg_stuff;
                used = 0;
                if (pts != 0 && dts != 0 && (pts != dts || (video && !mpgv))) begin
                    flags = FLAGS_PTS_DTS;
                    if (hs == 0) hs = 10;
                end else if (pts != 0) begin
                    flags = FLAGS_PTS;
                    if (hs == 0) hs = 5;
                end else begin
                    flags = FLAGS_NONE;
                end
                if (ext) hs += 3;
                len = unbounded ? 16'd0 : 16'(size + extra + 3 + hs);
                hdr_bytes.push_back(len[15:8]);
                hdr_bytes.push_back(len[7:0]);
                hdr_bytes.push_back(BYTE_HIGH | {5'd0, cfg_align, 2'b00});
                hdr_bytes.push_back({flags, 5'd0, ext});
                hdr_bytes.push_back(8'(hs));
                if (flags[1]) begin
                    append_timestamp({2'b00, flags}, pts);
                    used += 5;
                end
                if (flags[0]) begin
                    append_timestamp(4'd1, dts);
                    used += 5;
                end
                if (ext) begin
                    hdr_bytes.push_back(BYTE_MARKER);
                    hdr_bytes.push_back(BYTE_EXT_FLG);
                    hdr_bytes.push_back({1'b1, extid});
                    used += 3;
                end
                while (used < hs) begin
                    hdr_bytes.push_back(BYTE_STUFF);
                    used++;
                end
            end else begin
                if (pts != 0 && dts != 0 && (pts != dts || video)) begin
                    flags = FLAGS_PTS_DTS;
                    add   = 10;
                end else if (pts != 0) begin
                    flags = FLAGS_PTS;
                    add   = 5;
                end else begin
                    flags = FLAGS_NONE;
                    add   = 1;
                end
                len = unbounded ? 16'd0 : 16'(size + extra + add);
                hdr_bytes.push_back(len[15:8]);
                hdr_bytes.push_back(len[7:0]);
                if (flags[1]) append_timestamp({2'b00, flags}, pts);
                if (flags[0]) append_timestamp(4'd1, dts);
                if (flags == FLAGS_NONE) hdr_bytes.push_back(BYTE_MARKER);
            end
            if (priv) begin
                hdr_bytes.push_back(pid);
                if (pid[7:4] == AC3_NIBBLE) begin
                    hdr_bytes.push_back(8'h00);
                    hdr_bytes.push_back(8'h00);
                    hdr_bytes.push_back(8'h00);
                end
            end
        end
        nbytes = hdr_bytes.size();
        for (i = 0; i * 8 < nbytes; i++) begin
            cnt    = (nbytes - i * 8 > 8) ? 8 : nbytes - i * 8;
            w.word = '0;
            for (k = 0; k < cnt; k++) begin
                w.word[63 - 8 * k -: 8] = hdr_bytes[i * 8 + k];
            end
            w.count = 4'(cnt);
            w.hlen  = 9'(nbytes);
            w.last  = ((i + 1) * 8 >= nbytes);
            expected_words.push_back(w);
        end
    endtask

    task automatic check_word();
        hdr_word_t w;
        if (expected_words.size() == 0) begin
            $error("header_word %h popped with no request outstanding", o_header_word);
            err_count++;
        end else begin
            w = expected_words.pop_front();
            if (o_header_word !== w.word) begin
                $error("header_word: expected %h, actual %h", w.word, o_header_word);
                err_count++;
            end
            if (o_byte_count !== w.count) begin
                $error("byte_count: expected %0d, actual %0d", w.count, o_byte_count);
                err_count++;
            end
            if (o_header_length !== w.hlen) begin
                $error("header_length: expected %0d, actual %0d", w.hlen, o_header_length);
                err_count++;
            end
            if (o_last_word !== w.last) begin
                $error("last_word: expected %0b, actual %0b", w.last, o_last_word);
                err_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_mpeg2 = 1'b1;
            cfg_align = 1'b0;
            cfg_stuff = 8'd0;
            expected_words.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_MPEG2: cfg_mpeg2 = pwdata[0];
                    REG_ALIGN: cfg_align = pwdata[0];
                    REG_STUFF: cfg_stuff = pwdata[7:0];
                    default: ;
                endcase
            end
            if (push && !full) begin
                build_header(i_pts, i_dts, i_payload_size, i_stream_code,
                             i_is_video, i_is_mpeg_video);
            end
            if (pop && !empty) check_word();
        end
        o_errors  <= err_count;
        o_pending <= expected_words.size();
    end

endmodule

### verif/pes_header_generator_tb.sv
// ----------------------------------------------------------------------------
// PES header generator testbench
// Sends directed and random PES packet requests through several register
// settings with random stalls on both queues; a checker module predicts and
// compares every header word.
// ----------------------------------------------------------------------------
module pes_header_generator_tb;
    import phg_pkg::*;

    localparam logic [1:0] REG_SPARE      = 2'd3;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         PHASE_ITEMS    = 24;
    localparam int         NUM_PHASES     = 8;
    localparam int         NUM_DIRECTED   = 23;

    typedef struct {
        logic [32:0] pts;
        logic [32:0] dts;
        logic [23:0] size;
        logic [15:0] code;
        logic        video;
        logic        mpgv;
    } pes_req_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        push;
    logic        full;
    logic [32:0] i_pts;
    logic [32:0] i_dts;
    logic [23:0] i_payload_size;
    logic [15:0] i_stream_code;
    logic        i_is_video;
    logic        i_is_mpeg_video;
    logic        empty;
    logic        pop = 1'b0;
    logic [63:0] o_header_word;
    logic [3:0]  o_byte_count;
    logic [8:0]  o_header_length;
    logic        o_last_word;

    int          mismatch_count;
    int          pending_words;
    int          pop_hold = 0;
    int          stall_cycles = 0;
    int          idle_pct = 0;
    logic        no_idle = 1'b0;

    logic [15:0] short_codes [8] = '{16'h00BC, 16'h00BE, 16'h00BF, 16'h00F0,
                                     16'h00F1, 16'h00F2, 16'h00F8, 16'h00FF};

    pes_header_generator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .push            (push),
        .full            (full),
        .i_pts           (i_pts),
        .i_dts           (i_dts),
        .i_payload_size  (i_payload_size),
        .i_stream_code   (i_stream_code),
        .i_is_video      (i_is_video),
        .i_is_mpeg_video (i_is_mpeg_video),
        .empty           (empty),
        .pop             (pop),
        .o_header_word   (o_header_word),
        .o_byte_count    (o_byte_count),
        .o_header_length (o_header_length),
        .o_last_word     (o_last_word)
    );

    pes_header_checker u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .push            (push),
        .full            (full),
        .i_pts           (i_pts),
        .i_dts           (i_dts),
        .i_payload_size  (i_payload_size),
        .i_stream_code   (i_stream_code),
        .i_is_video      (i_is_video),
        .i_is_mpeg_video (i_is_mpeg_video),
        .empty           (empty),
        .pop             (pop),
        .o_header_word   (o_header_word),
        .o_byte_count    (o_byte_count),
        .o_header_length (o_header_length),
        .o_last_word     (o_last_word),
        .o_errors        (mismatch_count),
        .o_pending       (pending_words)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (pop_hold > 0) begin
            pop_hold <= pop_hold - 1;
            pop      <= 1'b0;
        end else if (!no_idle && $urandom_range(99) < idle_pct) begin
            pop_hold <= $urandom_range(12);
            pop      <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (psel && penable)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic [32:0] rand_timestamp();
        case ($urandom_range(5))
            0, 1:    return 33'd0;
            2:       return '1;
            3:       return 33'($urandom_range(1000, 1));
            default: return {1'($urandom), 32'($urandom)};
        endcase
    endfunction

    function automatic pes_req_t rand_request();
        pes_req_t r;
        r.pts = rand_timestamp();
        case ($urandom_range(3))
            0:       r.dts = r.pts;
            1:       r.dts = 33'd0;
            default: r.dts = rand_timestamp();
        endcase
        case ($urandom_range(7))
            0:       r.size = 24'($urandom);
            1:       r.size = 24'($urandom_range(65600, 65400));
            2:       r.size = 24'(MAX_PAYLOAD);
            3:       r.size = 24'(MAX_PAYLOAD + 1);
            default: r.size = 24'($urandom_range(2000));
        endcase
        case ($urandom_range(6))
            0:       r.code = short_codes[$urandom_range(7)];
            1:       r.code = {ID_PRIVATE_1, 8'($urandom_range(8'h8F, 8'h80))};
            2:       r.code = {ID_PRIVATE_1, 8'($urandom)};
            3:       r.code = {ID_EXTENDED, 8'($urandom)};
            4:       r.code = 16'($urandom);
            default: r.code = {8'h00, 8'($urandom)};
        endcase
        r.video = 1'($urandom);
        r.mpgv  = 1'($urandom);
        return r;
    endfunction

    function automatic pes_req_t directed_request(int n);
        pes_req_t r;
        r = '{pts: 33'd0, dts: 33'd0, size: 24'd0, code: 16'h00E0, video: 1'b0, mpgv: 1'b0};
        case (n)
            0: begin
                r.video = 1'b1;
                r.mpgv  = 1'b1;
            end
            1: begin
                r.pts  = '1;
                r.size = 24'(MAX_PAYLOAD);
                r.code = 16'h00C0;
            end
            2: begin
                r.pts   = 33'd1;
                r.dts   = '1;
                r.size  = 24'(MAX_PAYLOAD + 1);
                r.video = 1'b1;
            end
            3: begin
                r.pts   = 33'd90000;
                r.dts   = 33'd90000;
                r.video = 1'b1;
                r.mpgv  = 1'b1;
            end
            4: begin
                r.pts   = 33'd90000;
                r.dts   = 33'd90000;
                r.video = 1'b1;
            end
            5: begin
                r.pts = 33'd5;
                r.dts = 33'd5;
            end
            6, 7, 8, 9, 10, 11, 12, 13: begin
                r.code = short_codes[n - 6];
                r.size = (n == 13) ? 24'hFFFFFF : 24'((n - 6) * 9361);
            end
            14: begin
                r.code = 16'hBD80;
                r.pts  = 33'd7;
                r.dts  = 33'd3;
            end
            15: begin
                r.code = 16'hBD8F;
                r.size = 24'(MAX_PAYLOAD);
                r.pts  = 33'h155555555;
            end
            16: r.code = 16'hBD20;
            17: r.code = 16'hBD90;
            18: begin
                r.code = 16'hFDFF;
                r.pts  = 33'h0AAAAAAAA;
                r.dts  = 33'h100000000;
            end
            19: r.code = 16'hFD00;
            20: begin
                r.code = 16'h12BC;
                r.pts  = 33'd1234;
            end
            21: r.code = 16'hFFFF;
            default: begin
                r.code = 16'h00FF;
                r.pts  = 33'd99;
                r.size = 24'd17;
            end
        endcase
        return r;
    endfunction

    task automatic send_request(input pes_req_t r);
        if (!no_idle && $urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            repeat ($urandom_range(13, 1)) @(posedge i_clk);
        end
        push            <= 1'b1;
        i_pts           <= r.pts;
        i_dts           <= r.dts;
        i_payload_size  <= r.size;
        i_stream_code   <= r.code;
        i_is_video      <= r.video;
        i_is_mpeg_video <= r.mpgv;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    logic       phase_mpeg2 [NUM_PHASES] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    logic       phase_align [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
    logic [7:0] phase_stuff [NUM_PHASES] = '{8'd0, 8'd255, 8'd1, 8'd200,
                                             8'd10, 8'd0, 8'd7, 8'd3};
    int         phase_idle  [NUM_PHASES] = '{30, 0, 60, 30, 15, 50, 30, 0};

    initial begin
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = 4'd0;
        pwdata          = 32'd0;
        push            = 1'b0;
        i_pts           = 33'd0;
        i_dts           = 33'd0;
        i_payload_size  = 24'd0;
        i_stream_code   = 16'd0;
        i_is_video      = 1'b0;
        i_is_mpeg_video = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        idle_pct <= 25;
        for (int n = 0; n < NUM_DIRECTED; n++) begin
            send_request(directed_request(n));
        end
        wait_drain();
        for (int p = 0; p < NUM_PHASES; p++) begin
            idle_pct <= phase_idle[p];
            no_idle  <= (p == NUM_PHASES - 1);
            write_reg(REG_MPEG2, {31'($urandom), phase_mpeg2[p]});
            write_reg(REG_ALIGN, {31'($urandom), phase_align[p]});
            write_reg(REG_STUFF, {24'($urandom), phase_stuff[p]});
            if (p == 3) write_reg(REG_SPARE, $urandom);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_request(rand_request());
            end
            wait_drain();
        end
        if (mismatch_count == 0 && pending_words == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
